// ===== sv/dcts_pkg.sv =====
// Package for the diagnostic code table sorter: entry type, action codes,
// lamp masks, rank function and ordering function. No dependencies.
`timescale 1ns / 1ps
package dcts_pkg;

    typedef enum logic [1:0] {
        ACT_HEADER = 2'd0,
        ACT_RECORD = 2'd1,
        ACT_OBD    = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef struct packed {
        logic        kind;
        logic [7:0]  lamps;
        logic [7:0]  source;
        logic [6:0]  count;
        logic [4:0]  mode;
        logic [18:0] spn;
        logic        pending;
        logic [15:0] code;
    } t_entry;

    localparam logic [7:0] LAMP_RED   = 8'h30;
    localparam logic [7:0] LAMP_MIL   = 8'hC0;
    localparam logic [7:0] LAMP_AMBER = 8'h0C;

    function automatic logic [1:0] rank_of(input t_entry e);
        logic [1:0] r;
        if (e.kind) r = e.pending ? 2'd3 : 2'd1;
        else if ((e.lamps & LAMP_RED) != 8'h00) r = 2'd0;
        else if ((e.lamps & LAMP_MIL) != 8'h00) r = 2'd1;
        else if ((e.lamps & LAMP_AMBER) != 8'h00) r = 2'd2;
        else r = 2'd3;
        return r;
    endfunction

    // Entry b should go ahead of entry a.
    function automatic logic goes_first(input t_entry a, input t_entry b);
        logic [1:0] ra;
        logic [1:0] rb;
        ra = rank_of(a);
        rb = rank_of(b);
        return (rb < ra) || ((rb == ra) && (b.count > a.count));
    endfunction

endpackage

// ===== sv/dcts_compare.sv =====
// Shared compare unit: decides whether the probe entry goes ahead of the
// anchor entry during the exchange sort. Uses dcts_pkg.
`timescale 1ns / 1ps
module dcts_compare (
    input  dcts_pkg::t_entry i_anchor,
    input  dcts_pkg::t_entry i_probe,
    output logic             o_swap
);
    assign o_swap = dcts_pkg::goes_first(i_anchor, i_probe);
endmodule

// ===== sv/diagnostic_code_table_sorter.sv =====
// Diagnostic code table sorter: fault table, exchange sort, list emission.
// Records are stored unless blank or out of room; the last record starts
// N*(N-1)/2 compare steps (one per cycle on the shared compare unit), then
// entries go out one at a time, each held until the consumer is ready. OBD
// report: search for the code, then a pending update, or an append and a
// sort; then emission. Synchronous active-low reset clears control.
`timescale 1ns / 1ps
module diagnostic_code_table_sorter #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_source_addr,
    input  logic [7:0]  i_lamp_byte,
    input  logic [10:0] i_frame_len,
    input  logic [31:0] i_record_word,
    input  logic        i_last_record,
    input  logic [15:0] i_obd_code,
    input  logic        i_obd_pending,
    input  logic        i_obd_mil,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_entry_valid,
    output logic        o_entry_kind,
    output logic [18:0] o_suspect_number,
    output logic [4:0]  o_failure_mode,
    output logic [6:0]  o_occurrences,
    output logic [7:0]  o_entry_source,
    output logic [7:0]  o_entry_lamps,
    output logic [15:0] o_entry_obd_code,
    output logic        o_entry_pending,
    output logic        o_list_last
);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SEARCH, S_SORT, S_EMIT, S_WAIT
    } t_state;

    // Table held in registers; the sort swaps at most one pair of entries per step.
    dcts_pkg::t_entry r_tab [TABLE_DEPTH];
    t_state      r_state;
    logic [CW-1:0] r_count;
    logic [10:0] r_offset, r_flen;
    logic [7:0]  r_src, r_lamps;
    logic [IW-1:0] r_i, r_j, r_k;
    logic [15:0] r_code;
    logic        r_pend, r_mil;
    logic        r_ovalid;
    dcts_pkg::t_entry r_out;
    logic        r_olast, r_oentry;

    logic w_swap;
    dcts_compare u_cmp (
        .i_anchor(r_tab[r_i]),
        .i_probe (r_tab[r_j]),
        .o_swap  (w_swap)
    );

    // Record decode.
    logic [7:0]  w_b0, w_b1, w_b2, w_b3;
    logic [18:0] w_spn;
    logic        w_fits, w_blank;
    dcts_pkg::t_entry w_rec;
    always_comb begin
        w_b0  = i_record_word[7:0];
        w_b1  = i_record_word[15:8];
        w_b2  = i_record_word[23:16];
        w_b3  = i_record_word[31:24];
        w_spn = {w_b2[7:5], w_b1, w_b0};
        w_fits = ({1'b0, r_offset} + 12'd4 <= {1'b0, r_flen});
        w_blank = (i_record_word == 32'hFFFF_FFFF)
               || (w_spn == 19'd0 && w_b2[4:0] == 5'd0 && w_b3[6:0] == 7'd0);
        w_rec = '0;
        w_rec.spn    = w_spn;
        w_rec.mode   = w_b2[4:0];
        w_rec.count  = w_b3[6:0];
        w_rec.source = r_src;
        w_rec.lamps  = r_lamps;
    end

    logic w_full;
    assign w_full  = (r_count == CW'(TABLE_DEPTH));
    assign o_ready = (r_state == S_IDLE);
    logic w_acc;
    assign w_acc = i_valid && o_ready;

    // Last index of the table, as index width.
    logic [IW-1:0] w_lastk;
    assign w_lastk = IW'(r_count - CW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_offset <= 11'd2;
            r_flen   <= '0;
            r_src    <= '0;
            r_lamps  <= '0;
            r_ovalid <= 1'b0;
            r_i <= '0;
            r_j <= '0;
            r_k <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        case (dcts_pkg::t_action'(i_action))
                            dcts_pkg::ACT_HEADER: begin
                                r_count  <= '0;
                                r_src    <= i_source_addr;
                                r_lamps  <= i_lamp_byte;
                                r_flen   <= i_frame_len;
                                r_offset <= 11'd2;
                            end
                            dcts_pkg::ACT_RECORD: begin
                                if (w_fits && !w_full) begin
                                    r_offset <= r_offset + 11'd4;
                                    if (!w_blank) begin
                                        r_tab[r_count[IW-1:0]] <= w_rec;
                                        r_count <= r_count + CW'(1);
                                    end
                                end
                                if (i_last_record) begin
                                    r_i <= '0;
                                    r_j <= IW'(1);
                                    r_state <= S_SORT;
                                end
                            end
                            dcts_pkg::ACT_OBD: begin
                                if (!w_full) begin
                                    r_code  <= i_obd_code;
                                    r_pend  <= i_obd_pending;
                                    r_mil   <= i_obd_mil;
                                    r_k     <= '0;
                                    r_state <= S_SEARCH;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SEARCH: begin
                    // Walk entries one a cycle looking for the same OBD code.
                    if (r_count == '0 || {1'b0, r_k} >= r_count) begin
                        r_tab[r_count[IW-1:0]] <= '{kind: 1'b1,
                            lamps: r_mil ? dcts_pkg::LAMP_MIL : 8'h00,
                            source: 8'h00, count: 7'd0, mode: 5'd0,
                            spn: 19'd0, pending: r_pend, code: r_code};
                        r_count <= r_count + CW'(1);
                        r_i <= '0;
                        r_j <= IW'(1);
                        r_state <= S_SORT;
                    end else if (r_tab[r_k].kind && r_tab[r_k].code == r_code) begin
                        r_tab[r_k].pending <= r_pend;
                        r_k <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_k <= r_k + IW'(1);
                    end
                end
                S_SORT: begin
                    // One compare-and-swap per cycle over pairs i < j.
                    if (r_count <= CW'(1) || {1'b0, r_i} >= r_count - CW'(1)) begin
                        r_k <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        if (w_swap) begin
                            r_tab[r_i] <= r_tab[r_j];
                            r_tab[r_j] <= r_tab[r_i];
                        end
                        if (r_j == w_lastk) begin
                            r_i <= r_i + IW'(1);
                            r_j <= r_i + IW'(2);
                        end else begin
                            r_j <= r_j + IW'(1);
                        end
                    end
                end
                S_EMIT: begin
                    // Load one result into the output register.
                    r_ovalid <= 1'b1;
                    if (r_count == '0) begin
                        r_out    <= '0;
                        r_oentry <= 1'b0;
                        r_olast  <= 1'b1;
                    end else begin
                        r_out    <= r_tab[r_k];
                        r_oentry <= 1'b1;
                        r_olast  <= (r_k == w_lastk);
                    end
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (i_ready) begin
                        r_ovalid <= 1'b0;
                        if (r_olast) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k <= r_k + IW'(1);
                            r_state <= S_EMIT;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid          = r_ovalid;
    assign o_entry_valid    = r_oentry;
    assign o_entry_kind     = r_out.kind;
    assign o_suspect_number = r_out.spn;
    assign o_failure_mode   = r_out.mode;
    assign o_occurrences    = r_out.count;
    assign o_entry_source   = r_out.source;
    assign o_entry_lamps    = r_out.lamps;
    assign o_entry_obd_code = r_out.code;
    assign o_entry_pending  = r_out.pending;
    assign o_list_last      = r_olast;

    // Output valid only while waiting on the consumer.
    a_valid_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_WAIT)) else $error("valid outside wait");
    // Table never exceeds its depth.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH)) else $error("count overflow");
    // No input taken while a result is pending.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("ready while emitting");
endmodule
